// ===== rtl/core/ppid_pkg.sv =====
`timescale 1ns / 1ps
package ppid_pkg;

  typedef struct packed {
    logic [15:0] halfword;
    logic        frame_start;
  } in_word_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] error_code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_pixel;
  } out_word_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_VERSION, PH_WIDTH, PH_HEIGHT, PH_EXTRA,
    PH_RED, PH_GREEN, PH_BLUE, PH_ALPHA, PH_PIXELS, PH_PRODUCT
  } phase_t;

  localparam logic       KIND_PIXEL = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_VERSION = 2'd1;
  localparam logic [1:0] ERR_SIZE = 2'd2;

  typedef enum logic [1:0] {
    CMD_PIXEL, CMD_ERR_VERSION, CMD_ERR_SIZE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   cmd;
    logic [15:0] pixel;
    logic [4:0]  red_bits;
    logic [4:0]  green_bits;
    logic [4:0]  blue_bits;
    logic [4:0]  alpha_bits;
    logic        last_pixel;
  } cmd_t;

  // field*255/mask for a field of 1..16 bits, mask = 2^b-1.
  // f/mask is the b-bit field repeated as a binary fraction, so its top 8 bits
  // give floor(f*256/mask); that is the wanted value or one above it, and a
  // single compare settles which.
  function automatic logic [7:0] expand(input logic [15:0] px, input logic [4:0] bits,
                                        input logic [5:0] shift, input logic [7:0] none);
    logic [15:0] mask;
    logic [15:0] field;
    logic [7:0]  top;
    logic [4:0]  k;
    logic [24:0] rhs;
    logic [24:0] lhs;
    if (bits == 5'd0) begin
      return none;
    end
    mask = 16'((17'd1 << bits) - 17'd1);
    field = (shift >= 6'd16) ? 16'd0 : ((px >> shift[3:0]) & mask);
    k = bits - 5'd1;
    for (int j = 7; j >= 0; j--) begin
      top[j] = field[k[3:0]];
      k = (k == 5'd0) ? (bits - 5'd1) : (k - 5'd1);
    end
    rhs = 25'(top) * 25'(mask);
    lhs = 25'(field) * 25'd255;
    if (rhs > lhs) begin
      top = top - 8'd1;
    end
    return top;
  endfunction

endpackage

// ===== rtl/core/ppid_front.sv =====
`timescale 1ns / 1ps
module ppid_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppid_pkg::in_word_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ppid_pkg::cmd_t    cmd_data
);

  ppid_pkg::phase_t phase, phase_next;
  logic [15:0] low_half, low_half_next;
  logic        have_low, have_low_next;
  logic        is_v0, is_v0_next;
  logic [31:0] width, width_next;
  logic [31:0] height, height_next;
  logic [4:0]  rbits, gbits, bbits, abits;
  logic [4:0]  rbits_next, gbits_next, bbits_next, abits_next;
  logic [31:0] left, left_next;
  logic [31:0] word;
  logic [4:0]  clamp;
  logic        acc;

  assign word = {in_data.halfword, low_half};
  assign clamp = (word > 32'd16) ? 5'd16 : word[4:0];
  assign in_ready = (phase != ppid_pkg::PH_PRODUCT) && (!cmd_valid || cmd_ready);
  assign acc = in_valid && in_ready;

  logic        emit;
  ppid_pkg::cmd_t cmd_next;

  always_comb begin
    phase_next = phase;
    low_half_next = low_half;
    have_low_next = have_low;
    is_v0_next = is_v0;
    width_next = width;
    height_next = height;
    rbits_next = rbits;
    gbits_next = gbits;
    bbits_next = bbits;
    abits_next = abits;
    left_next = left;
    emit = 1'b0;
    cmd_next = '{cmd: ppid_pkg::CMD_PIXEL, pixel: in_data.halfword, red_bits: rbits,
                 green_bits: gbits, blue_bits: bbits, alpha_bits: abits,
                 last_pixel: (left == 32'd1)};
    if (phase == ppid_pkg::PH_PRODUCT) begin
      left_next = width * height;
      phase_next = (left_next == 32'd0) ? ppid_pkg::PH_IDLE : ppid_pkg::PH_PIXELS;
    end else if (acc) begin
      if (in_data.frame_start) begin
        phase_next = ppid_pkg::PH_VERSION;
        low_half_next = in_data.halfword;
        have_low_next = 1'b1;
      end else if (phase == ppid_pkg::PH_PIXELS) begin
        emit = 1'b1;
        left_next = left - 32'd1;
        if (left == 32'd1) begin
          phase_next = ppid_pkg::PH_IDLE;
        end
      end else if (phase != ppid_pkg::PH_IDLE) begin
        if (!have_low) begin
          low_half_next = in_data.halfword;
          have_low_next = 1'b1;
        end else begin
          have_low_next = 1'b0;
          case (phase)
            ppid_pkg::PH_VERSION: begin
              if (word > 32'd1) begin
                phase_next = ppid_pkg::PH_IDLE;
                emit = 1'b1;
                cmd_next.cmd = ppid_pkg::CMD_ERR_VERSION;
              end else begin
                is_v0_next = (word == 32'd0);
                phase_next = ppid_pkg::PH_WIDTH;
              end
            end
            ppid_pkg::PH_WIDTH: begin
              width_next = word;
              phase_next = ppid_pkg::PH_HEIGHT;
            end
            ppid_pkg::PH_HEIGHT: begin
              height_next = word;
              if (width == 32'd0 || word == 32'd0) begin
                phase_next = ppid_pkg::PH_IDLE;
                emit = 1'b1;
                cmd_next.cmd = ppid_pkg::CMD_ERR_SIZE;
              end else begin
                phase_next = is_v0 ? ppid_pkg::PH_EXTRA : ppid_pkg::PH_RED;
              end
            end
            ppid_pkg::PH_EXTRA: phase_next = ppid_pkg::PH_RED;
            ppid_pkg::PH_RED: begin
              rbits_next = clamp;
              phase_next = ppid_pkg::PH_GREEN;
            end
            ppid_pkg::PH_GREEN: begin
              gbits_next = clamp;
              phase_next = ppid_pkg::PH_BLUE;
            end
            ppid_pkg::PH_BLUE: begin
              bbits_next = clamp;
              phase_next = ppid_pkg::PH_ALPHA;
            end
            ppid_pkg::PH_ALPHA: begin
              abits_next = clamp;
              phase_next = ppid_pkg::PH_PRODUCT;
            end
            default: phase_next = phase;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ppid_pkg::PH_IDLE;
      have_low <= 1'b0;
      low_half <= 16'd0;
      is_v0 <= 1'b0;
      width <= 32'd0;
      height <= 32'd0;
      rbits <= 5'd0;
      gbits <= 5'd0;
      bbits <= 5'd0;
      abits <= 5'd0;
      left <= 32'd0;
      cmd_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      have_low <= have_low_next;
      low_half <= low_half_next;
      is_v0 <= is_v0_next;
      width <= width_next;
      height <= height_next;
      rbits <= rbits_next;
      gbits <= gbits_next;
      bbits <= bbits_next;
      abits <= abits_next;
      left <= left_next;
      if (emit) begin
        cmd_valid <= 1'b1;
      end else if (cmd_ready) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd_data <= cmd_next;
    end
  end

endmodule

// ===== rtl/core/ppid_back.sv =====
`timescale 1ns / 1ps
module ppid_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ppid_pkg::cmd_t     cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ppid_pkg::out_word_t out_data
);

  ppid_pkg::out_word_t res;
  logic [5:0] sb, sg, sr;

  assign cmd_ready = !out_valid || out_ready;
  assign sb = 6'd0;
  assign sg = 6'(cmd_data.blue_bits);
  assign sr = 6'(cmd_data.blue_bits) + 6'(cmd_data.green_bits);

  always_comb begin
    res = '0;
    case (cmd_data.cmd)
      ppid_pkg::CMD_PIXEL: begin
        res.kind = ppid_pkg::KIND_PIXEL;
        res.error_code = ppid_pkg::ERR_NONE;
        res.red = ppid_pkg::expand(cmd_data.pixel, cmd_data.red_bits, sr, 8'd0);
        res.green = ppid_pkg::expand(cmd_data.pixel, cmd_data.green_bits, sg, 8'd0);
        res.blue = ppid_pkg::expand(cmd_data.pixel, cmd_data.blue_bits, sb, 8'd0);
        res.alpha = ppid_pkg::expand(cmd_data.pixel, cmd_data.alpha_bits,
                                     sr + 6'(cmd_data.red_bits), 8'hff);
        res.last_pixel = cmd_data.last_pixel;
      end
      ppid_pkg::CMD_ERR_VERSION: begin
        res.kind = ppid_pkg::KIND_ERROR;
        res.error_code = ppid_pkg::ERR_VERSION;
      end
      ppid_pkg::CMD_ERR_SIZE: begin
        res.kind = ppid_pkg::KIND_ERROR;
        res.error_code = ppid_pkg::ERR_SIZE;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      out_data <= res;
    end
  end

endmodule

// ===== rtl/core/packed_pixel_image_decoder.sv =====
`timescale 1ns / 1ps
// Packed 16-bit pixel image decoder.
// in channel: in_valid/in_ready carry one halfword word of the file, with
//   frame_start on the first word of each file.
// out channel: out_valid/out_ready carry one result word per pixel or per
//   header error; header words give none.
// Path: an accepted word's command is registered in the front, and its
//   result is then registered in the back stage's output register.
// Throughput: one word per cycle while the command register has room; after
//   the alpha bit count a product state forms the pixel count width*height,
//   input held off then. Front parser feeds a one-entry command register; the
//   back stage expands channels into an output register, so each side stalls on its own.
// Reset: parser idles waiting for frame_start; nothing is pending.
// When the receiver stalls, out_ready low holds the result, the command
//   register fills and then in_ready drops.
module packed_pixel_image_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppid_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ppid_pkg::out_word_t out_data
);

  logic           cmd_valid;
  logic           cmd_ready;
  ppid_pkg::cmd_t cmd_data;

  ppid_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
  );

  ppid_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
    .cmd_data(cmd_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
